// ----- src/xcfc_pkg.sv -----
// Shared types and constants for the XOR checksum frame checker.
// No dependencies; imported by the front end, the back end and the top module, not by xcfc_fifo.
`timescale 1ns / 1ps

package xcfc_pkg;

    // Framing characters
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_STAR = 8'h2A;

    // Status codes reported on the last byte of a line
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_HASH  = 2'd1;
    localparam logic [1:0] ST_MISSING  = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    // Classified input item, as queued between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       is_hash;
        logic       is_star;
    } xcfc_item_t;

    // One result item
    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       frame_done;
        logic [1:0] status;
        logic [7:0] checksum;
    } xcfc_result_t;

    // Line parser phases, one-hot
    typedef enum logic [5:0] {
        PH_HASH     = 6'b000001,
        PH_BODY     = 6'b000010,
        PH_HEX      = 6'b000100,
        PH_TAIL_OK  = 6'b001000,
        PH_TAIL_BAD = 6'b010000,
        PH_SKIP     = 6'b100000
    } xcfc_phase_t;

    // Uppercase ASCII hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] wide;
        wide = {4'h0, nibble};
        if (nibble < 4'd10)
            hex_digit = 8'h30 + wide;
        else
            hex_digit = 8'h37 + wide;
    endfunction

endpackage

// ----- src/xcfc_fifo.sv -----
// Small register-based FIFO used for the item and result queues.
// No package dependencies; DEPTH must be a power of two, at least 2.
`timescale 1ns / 1ps

module xcfc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW:0]      wr_ptr_reg, wr_ptr_next;
    logic [AW:0]      rd_ptr_reg, rd_ptr_next;
    logic             do_push;
    logic             do_pop;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                   (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg[AW-1:0]];

    // Advance pointers on accepted transfers
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (AW+1)'(do_push);
        rd_ptr_next = rd_ptr_reg + (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg[AW-1:0]] <= wdata;
    end

endmodule

// ----- src/xcfc_front.sv -----
// Front end: accepts received bytes, classifies framing characters and queues them.
// Depends on xcfc_pkg and xcfc_fifo.
`timescale 1ns / 1ps

module xcfc_front
    import xcfc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] rx_byte,
    input  logic       last_byte,
    output logic       full,
    input  logic       item_pop,
    output xcfc_item_t item,
    output logic       item_empty
);

    xcfc_item_t classified;

    // Tag the framing characters
    always_comb
    begin
        classified.data    = rx_byte;
        classified.last    = last_byte;
        classified.is_hash = (rx_byte == CHAR_HASH);
        classified.is_star = (rx_byte == CHAR_STAR);
    end

    // Hold classified items for the back end
    xcfc_fifo #(
        .WIDTH($bits(xcfc_item_t)),
        .DEPTH(DEPTH)
    ) u_item_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (classified),
        .full  (full),
        .pop   (item_pop),
        .rdata (item),
        .empty (item_empty)
    );

endmodule

// ----- src/xcfc_back.sv -----
// Back end: runs the line parser and checksum compare, queues one result per item.
// Depends on xcfc_pkg and xcfc_fifo.
`timescale 1ns / 1ps

module xcfc_back
    import xcfc_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         checksum_required,
    input  xcfc_item_t   item,
    input  logic         item_empty,
    output logic         item_pop,
    input  logic         res_pop,
    output xcfc_result_t result,
    output logic         res_empty
);

    xcfc_phase_t  phase_reg, phase_next;
    logic [7:0]   xor_reg, xor_next;
    logic [7:0]   first_hex_reg, first_hex_next;
    logic         hex_one_reg, hex_one_next;
    logic         res_full;
    logic         step;
    logic         hex_match;
    xcfc_result_t res_new;

    // Take an item whenever there is room for its result
    assign step     = !item_empty && !res_full;
    assign item_pop = step;

    assign hex_match = (first_hex_reg == hex_digit(xor_reg[7:4])) &&
                       (item.data == hex_digit(xor_reg[3:0]));

    // Parser step for the item at the head of the queue
    always_comb
    begin
        phase_next          = phase_reg;
        xor_next            = xor_reg;
        first_hex_next      = first_hex_reg;
        hex_one_next        = hex_one_reg;
        res_new.body_valid  = 1'b0;
        res_new.body_byte   = 8'h00;
        res_new.frame_done  = item.last;
        res_new.status      = ST_OK;

        unique case (phase_reg) inside
            PH_HASH:
            begin
                if (item.is_hash)
                    phase_next = PH_BODY;
                else
                    phase_next = PH_SKIP;
            end
            PH_BODY:
            begin
                if (item.is_star)
                begin
                    phase_next   = PH_HEX;
                    hex_one_next = 1'b0;
                end
                else
                begin
                    res_new.body_valid = 1'b1;
                    res_new.body_byte  = item.data;
                    xor_next           = xor_reg ^ item.data;
                end
            end
            PH_HEX:
            begin
                if (!hex_one_reg)
                begin
                    first_hex_next = item.data;
                    hex_one_next   = 1'b1;
                end
                else if (hex_match)
                    phase_next = PH_TAIL_OK;
                else
                    phase_next = PH_TAIL_BAD;
            end
            PH_TAIL_OK, PH_TAIL_BAD, PH_SKIP:
            begin
                phase_next = phase_reg;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        res_new.checksum = xor_next;

        // Report status and clear for the next line
        if (item.last)
        begin
            if (phase_next == PH_SKIP)
                res_new.status = ST_NO_HASH;
            else if (phase_next == PH_BODY)
                res_new.status = checksum_required ? ST_MISSING : ST_OK;
            else if (phase_next == PH_TAIL_OK)
                res_new.status = ST_OK;
            else
                res_new.status = ST_MISMATCH;

            phase_next     = PH_HASH;
            xor_next       = 8'h00;
            first_hex_next = 8'h00;
            hex_one_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HASH;
            xor_reg       <= 8'h00;
            first_hex_reg <= 8'h00;
            hex_one_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            xor_reg       <= xor_next;
            first_hex_reg <= first_hex_next;
            hex_one_reg   <= hex_one_next;
        end
    end

    // Hold results until the consumer takes them
    xcfc_fifo #(
        .WIDTH($bits(xcfc_result_t)),
        .DEPTH(DEPTH)
    ) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step),
        .wdata (res_new),
        .full  (res_full),
        .pop   (res_pop),
        .rdata (result),
        .empty (res_empty)
    );

endmodule

// ----- src/xor_checksum_frame_checker.sv -----
// Checker for ASCII lines of the form '#body*HH' with an XOR checksum. One byte
// is taken per cycle while the input queue is not full, with a last-byte mark, and
// one result item comes out per byte: body bytes are passed on with the running XOR,
// and the item for the last byte carries the status (0 ok, 1 no leading '#',
// 2 checksum missing, 3 mismatch). Throughput is one item per clock while neither
// queue is full. The item queue behind the classifier registers the byte; the parser
// takes it once the result queue has room and writes its result into that queue.
// Each queue holds QUEUE_DEPTH items (a power of two, at least 2).
// Register 0 at byte address 0, bit 0: checksum_required (reset 1).
// Depends on xcfc_pkg, xcfc_fifo, xcfc_front and xcfc_back.
`timescale 1ns / 1ps

module xor_checksum_frame_checker
    import xcfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        last_byte,
    // Result queue side
    output logic        empty,
    input  logic        pop,
    output logic        body_valid,
    output logic [7:0]  body_byte,
    output logic        frame_done,
    output logic [1:0]  status,
    output logic [7:0]  computed_checksum,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_CHECKSUM_REQUIRED = 1'b0;

    logic         checksum_required_reg;
    logic         cfg_write;
    xcfc_item_t   item;
    logic         item_empty;
    logic         item_pop;
    xcfc_result_t result;

    // Configuration register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_CHECKSUM_REQUIRED);
    assign prdata    = (paddr[2] == REG_CHECKSUM_REQUIRED) ?
                       {31'b0, checksum_required_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            checksum_required_reg <= 1'b1;
        else if (cfg_write)
            checksum_required_reg <= pwdata[0];
    end

    xcfc_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .rx_byte    (rx_byte),
        .last_byte  (last_byte),
        .full       (full),
        .item_pop   (item_pop),
        .item       (item),
        .item_empty (item_empty)
    );

    xcfc_back #(
        .DEPTH(QUEUE_DEPTH)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .checksum_required (checksum_required_reg),
        .item              (item),
        .item_empty        (item_empty),
        .item_pop          (item_pop),
        .res_pop           (pop),
        .result            (result),
        .res_empty         (empty)
    );

    // Unpack the result item
    assign body_valid        = result.body_valid;
    assign body_byte         = result.body_byte;
    assign frame_done        = result.frame_done;
    assign status            = result.status;
    assign computed_checksum = result.checksum;

    // A status other than ok only on the last byte of a line
    a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !frame_done) |-> (status == ST_OK))
        else $error("status set on a result that does not end a line");

    // Non-body results carry a zero byte
    a_body_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !body_valid) |-> (body_byte == 8'h00))
        else $error("body_byte nonzero without body_valid");

    // A line without a leading hash passes no body
    a_no_hash_no_body: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_done && (status == ST_NO_HASH)) |-> !body_valid)
        else $error("body byte on a line without leading hash");

endmodule

// ----- tb/sv/frame_status_checker.sv -----
// Scoreboard for the XOR checksum frame checker: predicts every result item and compares.
// Watches the input queue, the result queue and the register port of the block.
// Depends on xcfc_pkg for the phase enum, the framing characters and the status codes.
`timescale 1ns / 1ps

module frame_status_checker
    import xcfc_pkg::*;
#(
    parameter logic [2:0] REQUIRED_ADDR = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        last_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic        body_valid,
    input  logic [7:0]  body_byte,
    input  logic        frame_done,
    input  logic [1:0]  status,
    input  logic [7:0]  computed_checksum,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          errors,
    output int          results_owed
);

    localparam logic [127:0] HEX_CHARS = "0123456789ABCDEF";

    // Shadow of the line parser and of the register
    xcfc_phase_t  line_phase;
    logic [7:0]   body_xor;
    logic [7:0]   hex_hi;
    logic [1:0]   hex_count;
    logic         hash_missing;
    logic         need_checksum;
    xcfc_result_t expected_results[$];

    initial errors = 0;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = HEX_CHARS[8 * (15 - int'(nib)) +: 8];
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors = errors + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        xcfc_result_t want;
        if (!rst_n)
        begin
            line_phase    = PH_HASH;
            body_xor      = 8'h00;
            hex_hi        = 8'h00;
            hex_count     = 2'd0;
            hash_missing  = 1'b0;
            need_checksum = 1'b1;
            expected_results.delete();
            results_owed <= 0;
        end
        else
        begin
            // Follow register writes, check register reads
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == REQUIRED_ADDR)
                        need_checksum = pwdata[0];
                end
                else if (paddr == REQUIRED_ADDR && prdata !== {31'd0, need_checksum})
                begin
                    $error("checksum_required: expected %0d, actual %0d", need_checksum, prdata);
                    errors = errors + 1;
                end
            end

            // Step the parser on each accepted item
            if (push && !full)
            begin
                want = '0;
                want.frame_done = last_byte;
                case (line_phase)
                    PH_HASH:
                        if (rx_byte == CHAR_HASH)
                            line_phase = PH_BODY;
                        else
                        begin
                            hash_missing = 1'b1;
                            line_phase   = PH_SKIP;
                        end
                    PH_BODY:
                        if (rx_byte == CHAR_STAR)
                        begin
                            line_phase = PH_HEX;
                            hex_count  = 2'd0;
                        end
                        else
                        begin
                            want.body_valid = 1'b1;
                            want.body_byte  = rx_byte;
                            body_xor        = body_xor ^ rx_byte;
                        end
                    PH_HEX:
                        if (hex_count == 2'd0)
                        begin
                            hex_hi    = rx_byte;
                            hex_count = 2'd1;
                        end
                        else
                        begin
                            hex_count = 2'd2;
                            if (hex_hi == hex_char(body_xor[7:4]) &&
                                rx_byte == hex_char(body_xor[3:0]))
                                line_phase = PH_TAIL_OK;
                            else
                                line_phase = PH_TAIL_BAD;
                        end
                    default:
                        ;
                endcase

                // Grade the line on its last byte
                if (last_byte)
                begin
                    if (hash_missing || line_phase == PH_SKIP)
                        want.status = ST_NO_HASH;
                    else if (line_phase == PH_BODY)
                        want.status = need_checksum ? ST_MISSING : ST_OK;
                    else if (line_phase == PH_TAIL_OK)
                        want.status = ST_OK;
                    else
                        want.status = ST_MISMATCH;
                end
                want.checksum = body_xor;
                expected_results.insert(expected_results.size(), want);

                if (last_byte)
                begin
                    line_phase   = PH_HASH;
                    body_xor     = 8'h00;
                    hex_hi       = 8'h00;
                    hex_count    = 2'd0;
                    hash_missing = 1'b0;
                end
            end

            // Compare each popped result with the oldest prediction
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no item waiting for it");
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("body_valid", {7'd0, want.body_valid}, {7'd0, body_valid});
                    check_field("body_byte", want.body_byte, body_byte);
                    check_field("frame_done", {7'd0, want.frame_done}, {7'd0, frame_done});
                    check_field("status", {6'd0, want.status}, {6'd0, status});
                    check_field("computed_checksum", want.checksum, computed_checksum);
                end
            end

            results_owed <= expected_results.size();
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top of the frame checker testbench: clock, reset, line stimulus, register writes, verdict.
// Depends on xcfc_pkg, xor_checksum_frame_checker and frame_status_checker.
`timescale 1ns / 1ps

module tb_top
    import xcfc_pkg::*;
();

    localparam logic [2:0] ADDR_CHECKSUM_REQUIRED = 3'd0;
    localparam logic [2:0] ADDR_UNUSED            = 3'd4;
    localparam int         RANDOM_ITEMS           = 400;
    localparam int         CYCLE_LIMIT            = 200000;
    localparam int         DRAIN_CYCLES           = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        push      = 1'b0;
    logic        full;
    logic [7:0]  rx_byte   = 8'h00;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop       = 1'b0;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        frame_done;
    logic [1:0]  status;
    logic [7:0]  computed_checksum;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int results_owed;
    int items_sent    = 0;
    int cycles        = 0;
    int push_idle_pct = 11;
    int pop_idle_pct  = 11;

    logic [7:0] line_buf[$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    xor_checksum_frame_checker dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .rx_byte(rx_byte), .last_byte(last_byte),
        .empty(empty), .pop(pop), .body_valid(body_valid), .body_byte(body_byte),
        .frame_done(frame_done), .status(status), .computed_checksum(computed_checksum),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    frame_status_checker #(
        .REQUIRED_ADDR(ADDR_CHECKSUM_REQUIRED)
    ) scoreboard (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .rx_byte(rx_byte), .last_byte(last_byte),
        .empty(empty), .pop(pop), .body_valid(body_valid), .body_byte(body_byte),
        .frame_done(frame_done), .status(status), .computed_checksum(computed_checksum),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .errors(errors), .results_owed(results_owed)
    );

    // Drain results, stalling now and then
    always @(posedge clk)
        pop <= rst_n && ($urandom_range(99) >= pop_idle_pct);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Append one byte to the line being built
    task automatic append_byte(input logic [7:0] b);
        line_buf.insert(line_buf.size(), b);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic ends);
        int gap;
        if ($urandom_range(99) < push_idle_pct)
        begin
            gap = $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        rx_byte   <= b;
        last_byte <= ends;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    // Send line_buf, marking its final byte when the line ends here
    task automatic send_line(input logic ends);
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], ends && (i == line_buf.size() - 1));
    endtask

    task automatic send_text(input string s, input logic ends);
        line_buf.delete();
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
        send_line(ends);
    endtask

    // Hold the sender until every predicted result has been popped
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (results_owed != 0);
    endtask

    task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly well-formed lines with random bodies; some damaged lines and raw noise
    task automatic build_random_line();
        int         kind;
        int         len;
        logic [7:0] b;
        logic [7:0] sum;
        string      hx;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind >= 88)
        begin
            len = $urandom_range(1, 6);
            repeat (len)
                append_byte(8'($urandom_range(255)));
            return;
        end
        sum = 8'h00;
        append_byte(CHAR_HASH);
        len = $urandom_range(0, 8);
        repeat (len)
        begin
            b = 8'($urandom_range(255));
            if (b == CHAR_STAR)
                b = 8'h2B;
            sum = sum ^ b;
            append_byte(b);
        end
        if (kind < 70)
        begin
            if (kind < 64)
                hx = $sformatf("%02X", sum);
            else if (kind < 67)
                hx = $sformatf("%02x", sum);
            else
                hx = $sformatf("%02X", sum ^ (8'd1 << $urandom_range(7)));
            append_byte(CHAR_STAR);
            append_byte(hx[0]);
            append_byte(hx[1]);
            len = $urandom_range(0, 2);
            repeat (len)
                append_byte(8'($urandom_range(255)));
        end
        else if (kind >= 80)
        begin
            // short checksum
            hx = $sformatf("%02X", sum);
            append_byte(CHAR_STAR);
            if ($urandom_range(1))
                append_byte(hx[0]);
        end
    endtask

    task automatic run_random(input int target);
        while (items_sent < target)
        begin
            build_random_line();
            send_line(1'b1);
        end
    endtask

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        reg_access(1'b0, ADDR_CHECKSUM_REQUIRED, 32'd0);

        // Lone hash while a checksum is required
        send_text("#", 1'b1);
        // Lowercase checksum digits
        send_text("#J*4a", 1'b1);
        // Missing hash, hash arriving too late
        send_text("Q#", 1'b1);
        // Short checksum
        send_text("#*0", 1'b1);
        // Extreme body bytes, then stars after the checksum
        line_buf.delete();
        append_byte(CHAR_HASH);
        append_byte(8'hFF);
        append_byte(8'h00);
        append_byte(CHAR_STAR);
        append_byte("F");
        append_byte("F");
        append_byte(CHAR_STAR);
        append_byte(CHAR_STAR);
        send_line(1'b1);

        // Write a register that does not exist, then clear the requirement
        wait_drained();
        reg_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF);
        reg_access(1'b0, ADDR_CHECKSUM_REQUIRED, 32'd0);
        reg_access(1'b1, ADDR_CHECKSUM_REQUIRED, 32'hFFFF_FFFE);
        send_text("#", 1'b1);

        // Change the register in the middle of a line
        send_text("#7", 1'b0);
        wait_drained();
        reg_access(1'b1, ADDR_CHECKSUM_REQUIRED, 32'd1);
        send_text("F", 1'b1);

        // Random lines with the checksum required
        run_random(150);

        // Random lines, checksum optional, no idling on either side
        wait_drained();
        reg_access(1'b1, ADDR_CHECKSUM_REQUIRED, 32'd0);
        reg_access(1'b0, ADDR_CHECKSUM_REQUIRED, 32'd0);
        push_idle_pct = 0;
        pop_idle_pct  = 0;
        run_random(300);

        // Back to required, with idling
        wait_drained();
        push_idle_pct = 11;
        pop_idle_pct  = 11;
        reg_access(1'b1, ADDR_CHECKSUM_REQUIRED, 32'd1);
        run_random(RANDOM_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
